### rtl/core/adjacent_swap_permutation_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacent swap permutation generator
// Same-cycle and next-cycle implication checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ADJACENT_SWAP_PERMUTATION_GENERATOR_ASSERT_SVH
`define ADJACENT_SWAP_PERMUTATION_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// ante holds -> cons holds in the same cycle
`define ASPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// ante holds -> cons holds in the next cycle
`define ASPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/aspg_pkg.sv
// ----------------------------------------------------------------------------
// aspg_pkg
// Shared widths, state type and result type of the permutation generator.
// ----------------------------------------------------------------------------
package aspg_pkg;

  localparam int CFG_W       = 5;
  localparam int LEFT_W      = 4;
  localparam int VALUE_W     = 5;
  localparam int COUNT_RESET = 16;
  localparam int COUNT_MIN   = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWAP_HI,
    ST_SWAP_LO,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               swap_valid;
    logic [LEFT_W-1:0]  left_position;
    logic [VALUE_W-1:0] moved_value;
    logic               finished;
  } result_t;

endpackage

### rtl/core/aspg_in_if.sv
// ----------------------------------------------------------------------------
// aspg_in_if
// Command channel: one word is a restart or advance request.
// ----------------------------------------------------------------------------
interface aspg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### rtl/core/aspg_out_if.sv
// ----------------------------------------------------------------------------
// aspg_out_if
// Result channel: one word reports the swap made by one command.
// ----------------------------------------------------------------------------
interface aspg_out_if;
  import aspg_pkg::*;

  logic               valid;
  logic               ready;
  logic               swap_valid;
  logic [LEFT_W-1:0]  left_position;
  logic [VALUE_W-1:0] moved_value;
  logic               finished;

  modport source (output valid, output swap_valid, output left_position,
                  output moved_value, output finished, input ready);
  modport sink   (input valid, input swap_valid, input left_position,
                  input moved_value, input finished, output ready);
endinterface

### rtl/core/aspg_ram.sv
// ----------------------------------------------------------------------------
// aspg_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aspg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/adjacent_swap_permutation_generator.sv
// ----------------------------------------------------------------------------
// adjacent_swap_permutation_generator
// Plain-changes permutation generator; each advance that does not finish swaps one adjacent pair.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per command; restart=1 reloads the identity row and all
//            directions left, restart=0 advances to the next permutation.
//   out_ch : one word per command: swap flag, left position of the swapped
//            pair, value that moved, and the finished flag.
//   cfg_we/cfg_wdata : element count n, clamped to 2..MAX_ELEMENTS; a write
//            also reloads the identity row. Write only while idle.
// Timing: restart and advances after finish go from accept through EMIT back
//   to IDLE. An advance that passes blocked elements before the one that moves
//   runs SEARCH, SWAP_HI, SWAP_LO, EMIT; the search reads one element per
//   cycle through the position RAM then the arrangement RAM, and the swap writes
//   in SWAP_HI then SWAP_LO on the single write port of each RAM.
// Reset: count 16 (or MAX_ELEMENTS if smaller), identity row, nothing done.
//   RAM entries carry valid bits; an unwritten entry reads as its own index.
// Stall: one output register; a finished result waits there and the next
//   command is taken; a further result holds until the register frees up.
// ----------------------------------------------------------------------------
`include "adjacent_swap_permutation_generator_assert.svh"

module adjacent_swap_permutation_generator #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  aspg_in_if.sink                   in_ch,
  aspg_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [aspg_pkg::CFG_W-1:0] cfg_wdata
);
  import aspg_pkg::*;

  localparam int IW         = $clog2(MAX_ELEMENTS);
  localparam int CNTW       = $clog2(MAX_ELEMENTS + 1);
  localparam int CW1        = CNTW + 1;
  localparam int COUNT_INIT = (COUNT_RESET < MAX_ELEMENTS) ? COUNT_RESET : MAX_ELEMENTS;

  state_t state_r, state_nxt;

  logic [CNTW-1:0]         count_r;
  logic [CNTW-1:0]         count_cfg;
  logic [MAX_ELEMENTS-1:0] dir_r;       // 1: element points left
  logic [MAX_ELEMENTS-1:0] arr_vld_r;
  logic [MAX_ELEMENTS-1:0] pos_vld_r;
  logic                    done_r;

  // search pipeline: A issues position read, B issues arrangement read, C tests
  logic [IW-1:0] ea_r, eb_r, ec_r, pc_r, qc_r;
  logic          a_v_r, b_v_r, c_v_r, open_c_r, left_c_r;

  logic [IW-1:0] sw_e_r, sw_p_r, sw_q_r, sw_other_r;
  result_t       res_r, out_r;
  logic          out_v_r;

  // RAM ports
  logic          arr_we, pos_we;
  logic [IW-1:0] arr_waddr, arr_wdata, pos_waddr, pos_wdata;
  logic [IW-1:0] arr_raddr, pos_raddr;
  logic [IW-1:0] arr_rdata, pos_rdata;

  logic          in_fire, out_free;
  logic [IW-1:0] pos_b, q_b, arr_c;
  logic          left_b, open_b, movable_c, last_c;

  aspg_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_arr_ram (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (arr_wdata),
    .raddr (arr_raddr),
    .rdata (arr_rdata)
  );

  aspg_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;

  always_comb begin
    if (int'(cfg_wdata) < COUNT_MIN) begin
      count_cfg = CNTW'(COUNT_MIN);
    end else if (int'(cfg_wdata) > MAX_ELEMENTS) begin
      count_cfg = CNTW'(MAX_ELEMENTS);
    end else begin
      count_cfg = CNTW'(cfg_wdata);
    end
  end

  // stage B: position of eb is back; work out its neighbor
  assign pos_b  = pos_vld_r[eb_r] ? pos_rdata : eb_r;
  assign left_b = dir_r[eb_r];
  assign open_b = left_b ? (pos_b != '0) : ((CW1'(pos_b) + CW1'(1)) < CW1'(count_r));
  assign q_b    = left_b ? (pos_b - IW'(1)) : (pos_b + IW'(1));

  // stage C: neighbor value is back
  assign arr_c     = arr_vld_r[qc_r] ? arr_rdata : qc_r;
  assign movable_c = c_v_r && open_c_r && (arr_c < ec_r);
  assign last_c    = c_v_r && !movable_c && (ec_r == IW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.restart || done_r) ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (movable_c) begin
          state_nxt = ST_SWAP_HI;
        end else if (last_c) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SWAP_HI: state_nxt = ST_SWAP_LO;
      ST_SWAP_LO: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs: handshake and RAM ports
  always_comb begin
    in_ch.ready = 1'b0;
    arr_we      = 1'b0;
    pos_we      = 1'b0;
    arr_waddr   = sw_q_r;
    arr_wdata   = sw_e_r;
    pos_waddr   = sw_e_r;
    pos_wdata   = sw_q_r;
    pos_raddr   = ea_r;
    arr_raddr   = q_b;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SWAP_HI: begin
        arr_we = 1'b1;
        pos_we = 1'b1;
      end
      ST_SWAP_LO: begin
        arr_we    = 1'b1;
        pos_we    = 1'b1;
        arr_waddr = sw_p_r;
        arr_wdata = sw_other_r;
        pos_waddr = sw_other_r;
        pos_wdata = sw_p_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= CNTW'(COUNT_INIT);
      dir_r     <= '1;
      arr_vld_r <= '0;
      pos_vld_r <= '0;
      done_r    <= 1'b0;
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // in EMIT a taken word is replaced by the new one below
      if (out_v_r && out_ch.ready && state_r != ST_EMIT) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.restart) begin
              res_r     <= '0;
              dir_r     <= '1;
              arr_vld_r <= '0;
              pos_vld_r <= '0;
              done_r    <= 1'b0;
            end else if (done_r) begin
              res_r <= '{swap_valid: 1'b0, left_position: '0, moved_value: '0,
                         finished: 1'b1};
            end else begin
              res_r <= '0;
              ea_r  <= IW'(count_r - CNTW'(1));
              a_v_r <= 1'b1;
              b_v_r <= 1'b0;
              c_v_r <= 1'b0;
            end
          end
        end
        ST_SEARCH: begin
          if (a_v_r) begin
            ea_r  <= ea_r - IW'(1);
            a_v_r <= (ea_r != IW'(1));
          end
          eb_r     <= ea_r;
          b_v_r    <= a_v_r;
          ec_r     <= eb_r;
          pc_r     <= pos_b;
          qc_r     <= q_b;
          open_c_r <= open_b;
          left_c_r <= left_b;
          c_v_r    <= b_v_r;
          if (movable_c) begin
            sw_e_r     <= ec_r;
            sw_p_r     <= pc_r;
            sw_q_r     <= qc_r;
            sw_other_r <= arr_c;
            res_r.swap_valid    <= 1'b1;
            res_r.left_position <= LEFT_W'(32'(left_c_r ? qc_r : pc_r));
            res_r.moved_value   <= VALUE_W'(32'(ec_r) + 32'd1);
            res_r.finished      <= 1'b0;
          end else if (c_v_r) begin
            // blocked: turn around and keep looking lower
            dir_r[ec_r] <= !dir_r[ec_r];
            if (last_c) begin
              done_r         <= 1'b1;
              res_r.finished <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_r   <= res_r;
            out_v_r <= 1'b1;
          end
        end
        default: ;
      endcase

      if (arr_we) begin
        arr_vld_r[arr_waddr] <= 1'b1;
      end
      if (pos_we) begin
        pos_vld_r[pos_waddr] <= 1'b1;
      end

      if (cfg_we) begin
        count_r   <= count_cfg;
        dir_r     <= '1;
        arr_vld_r <= '0;
        pos_vld_r <= '0;
        done_r    <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.swap_valid    = out_r.swap_valid;
  assign out_ch.left_position = out_r.left_position;
  assign out_ch.moved_value   = out_r.moved_value;
  assign out_ch.finished      = out_r.finished;

  `ASPG_ASSERT_IMP(a_search_not_done, clk, rst_n, state_r == ST_SEARCH, !done_r,
    "search running after the last permutation")
  `ASPG_ASSERT_IMP(a_search_floor, clk, rst_n, state_r == ST_SEARCH && c_v_r, ec_r != '0,
    "search reached the smallest element")
  `ASPG_ASSERT_NXT(a_restart_clears, clk, rst_n, in_fire && in_ch.restart,
    arr_vld_r == '0 && pos_vld_r == '0 && (&dir_r) && !done_r,
    "restart did not reload the identity row")
  `ASPG_ASSERT_IMP(a_swap_not_finished, clk, rst_n, out_v_r && out_r.swap_valid,
    !out_r.finished, "word reports a swap and finish together")

endmodule
